[sv/mfd_pkg.sv]
// Shared types, widths and codes of the Dinic maximum-flow engine.
package mfd_pkg;

  localparam int NODES     = 64;
  localparam int NODE_W    = 6;
  localparam int ARC_SLOTS = 512;
  localparam int ARC_AW    = 9;
  localparam int ARC_W     = 10;
  localparam int CAP_W     = 20;
  localparam int FLOW_W    = 21;
  localparam int RES_W     = 22;
  localparam int LVL_W     = 7;
  localparam int CNT_W     = 7;
  localparam int TOT_W     = 28;

  localparam logic [ARC_W-1:0] ARC_NONE = ARC_W'(ARC_SLOTS);
  localparam logic [LVL_W-1:0] LVL_NONE = '1;
  localparam logic [TOT_W-1:0] TOT_MAX  = '1;

  localparam logic [1:0] OPC_CLEAR = 2'd0;
  localparam logic [1:0] OPC_ADD   = 2'd1;
  localparam logic [1:0] OPC_RUN   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAME = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // datapath micro-operations
  localparam logic [5:0] OP_NOP      = 6'd0;
  localparam logic [5:0] OP_LATCH    = 6'd1;
  localparam logic [5:0] OP_CLR      = 6'd2;
  localparam logic [5:0] OP_ADD_CHK  = 6'd3;
  localparam logic [5:0] OP_ADD_RD   = 6'd4;
  localparam logic [5:0] OP_ADD_WR   = 6'd5;
  localparam logic [5:0] OP_ADD_LINK = 6'd6;
  localparam logic [5:0] OP_RUN_CHK  = 6'd7;
  localparam logic [5:0] OP_LV_CLR   = 6'd8;
  localparam logic [5:0] OP_LV_SRC   = 6'd9;
  localparam logic [5:0] OP_LV_POP   = 6'd10;
  localparam logic [5:0] OP_LV_NODE  = 6'd11;
  localparam logic [5:0] OP_LV_FIRST = 6'd12;
  localparam logic [5:0] OP_ARC_RD   = 6'd13;
  localparam logic [5:0] OP_ARC_HEAD = 6'd14;
  localparam logic [5:0] OP_LV_VISIT = 6'd15;
  localparam logic [5:0] OP_LV_END   = 6'd16;
  localparam logic [5:0] OP_CA_RD    = 6'd17;
  localparam logic [5:0] OP_CA_WR    = 6'd18;
  localparam logic [5:0] OP_AG_INIT  = 6'd19;
  localparam logic [5:0] OP_AG_TOP   = 6'd20;
  localparam logic [5:0] OP_AG_CUR   = 6'd21;
  localparam logic [5:0] OP_AG_TEST  = 6'd22;
  localparam logic [5:0] OP_AG_DEAD  = 6'd23;
  localparam logic [5:0] OP_AG_POP   = 6'd24;
  localparam logic [5:0] OP_AG_BACK  = 6'd25;
  localparam logic [5:0] OP_BN_START = 6'd26;
  localparam logic [5:0] OP_BN_READ  = 6'd27;
  localparam logic [5:0] OP_BN_MIN   = 6'd28;
  localparam logic [5:0] OP_UP_ARC   = 6'd29;
  localparam logic [5:0] OP_UP_FWD   = 6'd30;
  localparam logic [5:0] OP_UP_REVRD = 6'd31;
  localparam logic [5:0] OP_UP_REV   = 6'd32;
  localparam logic [5:0] OP_TOT      = 6'd33;
  localparam logic [5:0] OP_EMIT     = 6'd34;

  typedef struct packed {
    logic [5:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] opc;
    logic       full;
    logic       same_st;
    logic       qempty;
    logic       a_none;
    logic       t_reached;
    logic       sweep_last;
    logic       u_is_t;
    logic       found;
    logic       depth_full;
    logic       depth_zero;
    logic       k_more;
    logic       side;
    logic       out_free;
  } stat_t;

endpackage

[sv/mfd_ram.sv]
// Generic single-port RAM with registered read data.
module mfd_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] addr,
  input  logic [W-1:0]         wd,
  output logic [W-1:0]         rd
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    rd <= mem[addr];
  end
endmodule

[sv/mfd_dp.sv]
// Datapath of the flow engine: graph and scratch memories, registers, arithmetic.
module mfd_dp import mfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [1:0]        in_opcode,
  input  logic [NODE_W-1:0] in_from_node,
  input  logic [NODE_W-1:0] in_to_node,
  input  logic [CAP_W-1:0]  in_capacity,
  input  logic [NODE_W-1:0] in_source_node,
  input  logic [NODE_W-1:0] in_sink_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TOT_W-1:0]  out_max_flow,
  output logic [1:0]        out_status
);
  // latched item
  logic [1:0]        opc_r;
  logic [NODE_W-1:0] from_r, to_r, src_r, snk_r;
  logic [CAP_W-1:0]  cap_r;
  // graph bookkeeping
  logic [NODES-1:0]  node_v_r, node_v_nxt;
  logic [ARC_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;
  logic              side_r, side_nxt;
  logic              link_v_r, link_v_nxt;
  logic [ARC_W-1:0]  link_r, link_nxt;
  // walk registers
  logic [NODE_W-1:0] u_r, u_nxt, v_r, v_nxt, i_r, i_nxt;
  logic [ARC_W-1:0]  a_r, a_nxt, nx_r, nx_nxt;
  logic [LVL_W-1:0]  lu_r, lu_nxt;
  logic signed [RES_W-1:0] res_r, res_nxt, b_r, b_nxt;
  logic [CNT_W-1:0]  qh_r, qh_nxt, qt_r, qt_nxt, dep_r, dep_nxt, k_r, k_nxt;
  // output register
  logic              ov_r, ov_nxt;
  logic [TOT_W-1:0]  of_r, of_nxt;
  logic [1:0]        os_r, os_nxt;

  // memory ports
  logic              hd_we, cp_we, fl_we, nx_we;
  logic [ARC_AW-1:0] hd_a, cp_a, fl_a, nx_a;
  logic [NODE_W-1:0] hd_wd, hd_rd;
  logic [CAP_W-1:0]  cp_wd, cp_rd;
  logic [FLOW_W-1:0] fl_wd, fl_rd;
  logic [ARC_W-1:0]  nx_wd, nx_rd;
  logic              fa_we, la_we, lv_we, cu_we, qu_we, st_we;
  logic [NODE_W-1:0] fa_a, la_a, lv_a, cu_a, qu_a, st_a;
  logic [ARC_W-1:0]  fa_wd, fa_rd, la_wd, la_rd, cu_wd, cu_rd, st_wd, st_rd;
  logic [LVL_W-1:0]  lv_wd, lv_rd;
  logic [NODE_W-1:0] qu_wd, qu_rd;

  mfd_ram #(.W(NODE_W), .D(ARC_SLOTS)) u_head (.clk, .we(hd_we), .addr(hd_a), .wd(hd_wd), .rd(hd_rd));
  mfd_ram #(.W(CAP_W),  .D(ARC_SLOTS)) u_cap  (.clk, .we(cp_we), .addr(cp_a), .wd(cp_wd), .rd(cp_rd));
  mfd_ram #(.W(FLOW_W), .D(ARC_SLOTS)) u_flow (.clk, .we(fl_we), .addr(fl_a), .wd(fl_wd), .rd(fl_rd));
  mfd_ram #(.W(ARC_W),  .D(ARC_SLOTS)) u_next (.clk, .we(nx_we), .addr(nx_a), .wd(nx_wd), .rd(nx_rd));
  mfd_ram #(.W(ARC_W),  .D(NODES)) u_first (.clk, .we(fa_we), .addr(fa_a), .wd(fa_wd), .rd(fa_rd));
  mfd_ram #(.W(ARC_W),  .D(NODES)) u_last  (.clk, .we(la_we), .addr(la_a), .wd(la_wd), .rd(la_rd));
  mfd_ram #(.W(LVL_W),  .D(NODES)) u_level (.clk, .we(lv_we), .addr(lv_a), .wd(lv_wd), .rd(lv_rd));
  mfd_ram #(.W(ARC_W),  .D(NODES)) u_cur   (.clk, .we(cu_we), .addr(cu_a), .wd(cu_wd), .rd(cu_rd));
  mfd_ram #(.W(NODE_W), .D(NODES)) u_queue (.clk, .we(qu_we), .addr(qu_a), .wd(qu_wd), .rd(qu_rd));
  mfd_ram #(.W(ARC_W),  .D(NODES)) u_stack (.clk, .we(st_we), .addr(st_a), .wd(st_wd), .rd(st_rd));

  logic [NODE_W-1:0] tail, hd_sel;
  logic [ARC_W-1:0]  new_arc;
  logic signed [RES_W-1:0] res_now;
  logic              take, found, out_free;
  logic [TOT_W:0]    tot_sum;

  assign tail     = side_r ? to_r : from_r;
  assign hd_sel   = side_r ? from_r : to_r;
  assign new_arc  = cnt_r + ARC_W'(side_r);
  assign res_now  = $signed({2'b00, cp_rd}) - $signed({fl_rd[FLOW_W-1], fl_rd});
  assign take     = (lv_rd == LVL_NONE) && !res_r[RES_W-1] && (res_r != '0)
                    && !qt_r[CNT_W-1];
  assign found    = ({1'b0, lv_rd} == ({1'b0, lu_r} + 8'd1)) && !res_r[RES_W-1]
                    && (res_r != '0);
  assign out_free = !ov_r || out_ready;
  assign tot_sum  = {1'b0, tot_r} + (TOT_W+1)'(b_r[FLOW_W-1:0]);

  always_comb begin
    stat.opc        = opc_r;
    stat.full       = (cnt_r > ARC_W'(ARC_SLOTS - 2));
    stat.same_st    = (src_r == snk_r);
    stat.qempty     = (qh_r == qt_r);
    stat.a_none     = (a_r == ARC_NONE);
    stat.t_reached  = (lv_rd != LVL_NONE);
    stat.sweep_last = &i_r;
    stat.u_is_t     = (u_r == snk_r);
    stat.found      = found;
    stat.depth_full = dep_r[CNT_W-1];
    stat.depth_zero = (dep_r == '0);
    stat.k_more     = ((k_r + CNT_W'(1)) < dep_r);
    stat.side       = side_r;
    stat.out_free   = out_free;
  end

  always_comb begin
    node_v_nxt = node_v_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r; tot_nxt = tot_r;
    side_nxt = side_r; link_v_nxt = link_v_r; link_nxt = link_r;
    u_nxt = u_r; v_nxt = v_r; i_nxt = i_r; a_nxt = a_r; nx_nxt = nx_r; lu_nxt = lu_r;
    res_nxt = res_r; b_nxt = b_r; qh_nxt = qh_r; qt_nxt = qt_r; dep_nxt = dep_r;
    k_nxt = k_r;
    ov_nxt = ov_r && !out_ready; of_nxt = of_r; os_nxt = os_r;
    hd_we = 1'b0; cp_we = 1'b0; fl_we = 1'b0; nx_we = 1'b0;
    hd_a = a_r[ARC_AW-1:0]; cp_a = a_r[ARC_AW-1:0];
    fl_a = a_r[ARC_AW-1:0]; nx_a = a_r[ARC_AW-1:0];
    hd_wd = hd_sel; cp_wd = side_r ? '0 : cap_r; fl_wd = '0; nx_wd = ARC_NONE;
    fa_we = 1'b0; la_we = 1'b0; lv_we = 1'b0; cu_we = 1'b0; qu_we = 1'b0; st_we = 1'b0;
    fa_a = u_r; la_a = tail; lv_a = u_r; cu_a = u_r; qu_a = qh_r[NODE_W-1:0];
    st_a = k_r[NODE_W-1:0];
    fa_wd = new_arc; la_wd = new_arc; lv_wd = LVL_NONE; cu_wd = ARC_NONE; qu_wd = src_r;
    st_wd = a_r;
    unique case (cmd.op)
      OP_NOP: ;
      OP_LATCH: begin
        side_nxt = 1'b0;
      end
      OP_CLR: begin
        node_v_nxt = '0; cnt_nxt = '0; ovf_nxt = 1'b0; tot_nxt = '0;
      end
      OP_ADD_CHK: begin
        if (stat.full) ovf_nxt = 1'b1;
      end
      OP_ADD_RD: ;
      OP_ADD_WR: begin
        hd_a = new_arc[ARC_AW-1:0]; cp_a = new_arc[ARC_AW-1:0];
        fl_a = new_arc[ARC_AW-1:0]; nx_a = new_arc[ARC_AW-1:0];
        hd_we = 1'b1; cp_we = 1'b1; fl_we = 1'b1; nx_we = 1'b1;
        fa_a = tail; fa_we = !node_v_r[tail]; la_we = 1'b1;
        link_v_nxt = node_v_r[tail]; link_nxt = la_rd;
        node_v_nxt[tail] = 1'b1;
      end
      OP_ADD_LINK: begin
        nx_a = link_r[ARC_AW-1:0]; nx_wd = new_arc; nx_we = link_v_r;
        if (side_r) cnt_nxt = cnt_r + ARC_W'(2);
        side_nxt = !side_r;
      end
      OP_RUN_CHK: begin
        tot_nxt = '0; i_nxt = '0;
      end
      OP_LV_CLR: begin
        lv_a = i_r; lv_we = 1'b1; i_nxt = i_r + NODE_W'(1);
      end
      OP_LV_SRC: begin
        lv_a = src_r; lv_wd = '0; lv_we = 1'b1;
        qu_a = '0; qu_wd = src_r; qu_we = 1'b1;
        qh_nxt = '0; qt_nxt = CNT_W'(1);
      end
      OP_LV_POP: ;
      OP_LV_NODE: begin
        u_nxt = qu_rd; qh_nxt = qh_r + CNT_W'(1); lv_a = qu_rd; fa_a = qu_rd;
      end
      OP_LV_FIRST: begin
        lu_nxt = lv_rd; a_nxt = node_v_r[u_r] ? fa_rd : ARC_NONE;
      end
      OP_ARC_RD: ;
      OP_ARC_HEAD: begin
        v_nxt = hd_rd; res_nxt = res_now; nx_nxt = nx_rd; lv_a = hd_rd;
      end
      OP_LV_VISIT: begin
        if (take) begin
          lv_a = v_r; lv_wd = lu_r + LVL_W'(1); lv_we = 1'b1;
          qu_a = qt_r[NODE_W-1:0]; qu_wd = v_r; qu_we = 1'b1;
          qt_nxt = qt_r + CNT_W'(1);
        end
        a_nxt = nx_r;
      end
      OP_LV_END: begin
        lv_a = snk_r;
      end
      OP_CA_RD: begin
        fa_a = i_r;
      end
      OP_CA_WR: begin
        cu_a = i_r; cu_wd = node_v_r[i_r] ? fa_rd : ARC_NONE; cu_we = 1'b1;
        i_nxt = i_r + NODE_W'(1);
      end
      OP_AG_INIT: begin
        u_nxt = src_r; dep_nxt = '0;
      end
      OP_AG_TOP: ;
      OP_AG_CUR: begin
        a_nxt = cu_rd; lu_nxt = lv_rd;
      end
      OP_AG_TEST: begin
        if (found) begin
          cu_wd = a_r; cu_we = 1'b1;
          if (!stat.depth_full) begin
            st_a = dep_r[NODE_W-1:0]; st_wd = a_r; st_we = 1'b1;
            dep_nxt = dep_r + CNT_W'(1); u_nxt = v_r;
          end
        end else begin
          a_nxt = nx_r;
        end
      end
      OP_AG_DEAD: begin
        cu_we = 1'b1;
        st_a = NODE_W'(dep_r - CNT_W'(1));
        if (!stat.depth_zero) dep_nxt = dep_r - CNT_W'(1);
      end
      OP_AG_POP: begin
        a_nxt = st_rd;
        hd_a = {st_rd[ARC_AW-1:1], ~st_rd[0]}; nx_a = st_rd[ARC_AW-1:0];
      end
      OP_AG_BACK: begin
        u_nxt = hd_rd; cu_a = hd_rd; cu_wd = nx_rd; cu_we = 1'b1;
      end
      OP_BN_START: begin
        k_nxt = '0; st_a = '0;
      end
      OP_BN_READ: begin
        cp_a = st_rd[ARC_AW-1:0]; fl_a = st_rd[ARC_AW-1:0];
      end
      OP_BN_MIN: begin
        if ((k_r == '0) || (res_now < b_r)) b_nxt = res_now;
        k_nxt = k_r + CNT_W'(1);
        st_a = NODE_W'(k_r + CNT_W'(1));
        if (!stat.k_more) begin
          k_nxt = '0; st_a = '0;
        end
      end
      OP_UP_ARC: begin
        a_nxt = st_rd; fl_a = st_rd[ARC_AW-1:0];
      end
      OP_UP_FWD: begin
        fl_wd = fl_rd + b_r[FLOW_W-1:0]; fl_we = 1'b1;
      end
      OP_UP_REVRD: begin
        fl_a = {a_r[ARC_AW-1:1], ~a_r[0]};
      end
      OP_UP_REV: begin
        fl_a = {a_r[ARC_AW-1:1], ~a_r[0]};
        fl_wd = fl_rd - b_r[FLOW_W-1:0]; fl_we = 1'b1;
        k_nxt = k_r + CNT_W'(1);
        st_a = NODE_W'(k_r + CNT_W'(1));
      end
      OP_TOT: begin
        tot_nxt = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
      end
      OP_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1; of_nxt = tot_r;
          os_nxt = stat.same_st ? ST_SAME : (ovf_r ? ST_OVF : ST_OK);
          if (stat.same_st) of_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_v_r <= '0; cnt_r <= '0; ovf_r <= 1'b0; tot_r <= '0; ov_r <= 1'b0;
      side_r <= 1'b0; i_r <= '0; qh_r <= '0; qt_r <= '0; dep_r <= '0; k_r <= '0;
    end else begin
      node_v_r <= node_v_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; tot_r <= tot_nxt;
      ov_r <= ov_nxt; side_r <= side_nxt; i_r <= i_nxt; qh_r <= qh_nxt;
      qt_r <= qt_nxt; dep_r <= dep_nxt; k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      opc_r <= in_opcode; from_r <= in_from_node; to_r <= in_to_node;
      cap_r <= in_capacity; src_r <= in_source_node; snk_r <= in_sink_node;
    end
    link_v_r <= link_v_nxt; link_r <= link_nxt;
    u_r <= u_nxt; v_r <= v_nxt; a_r <= a_nxt; nx_r <= nx_nxt; lu_r <= lu_nxt;
    res_r <= res_nxt; b_r <= b_nxt; of_r <= of_nxt; os_r <= os_nxt;
  end

  assign out_valid    = ov_r;
  assign out_max_flow = of_r;
  assign out_status   = os_r;

`ifndef ASSERT_OFF
  a_cnt_even: assert property (@(posedge clk) disable iff (!rst_n)
    !cnt_r[0] && (cnt_r <= ARC_W'(ARC_SLOTS)))
    else $error("arc count odd or beyond table");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (qh_r <= qt_r) && (qt_r <= CNT_W'(NODES)))
    else $error("level queue pointers out of order");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    dep_r <= CNT_W'(NODES))
    else $error("path stack deeper than node count");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> (ov_r && $stable(of_r) && $stable(os_r)))
    else $error("result changed while waiting for transfer");
`endif
endmodule

[sv/mfd_ctrl.sv]
// Sequencer of the flow engine: steps the datapath through load, level and augment passes.
module mfd_ctrl import mfd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);
  localparam logic [5:0] S_IDLE = 6'd0,  S_DISP = 6'd1,  S_CLR = 6'd2,  S_ACHK = 6'd3;
  localparam logic [5:0] S_ARD = 6'd4,   S_AWR = 6'd5,   S_ALNK = 6'd6, S_RCHK = 6'd7;
  localparam logic [5:0] S_LCLR = 6'd8,  S_LSRC = 6'd9,  S_LPOP = 6'd10, S_LNOD = 6'd11;
  localparam logic [5:0] S_LFST = 6'd12, S_LARC = 6'd13, S_LHD = 6'd14, S_LVIS = 6'd15;
  localparam logic [5:0] S_LEND = 6'd16, S_LTST = 6'd17, S_CARD = 6'd18, S_CAWR = 6'd19;
  localparam logic [5:0] S_GINI = 6'd20, S_GTOP = 6'd21, S_GCUR = 6'd22, S_GSCN = 6'd23;
  localparam logic [5:0] S_GHD = 6'd24,  S_GTST = 6'd25, S_GDED = 6'd26, S_GPOP = 6'd27;
  localparam logic [5:0] S_GBCK = 6'd28, S_BST = 6'd29,  S_BRD = 6'd30, S_BMIN = 6'd31;
  localparam logic [5:0] S_UARC = 6'd32, S_UFWD = 6'd33, S_URRD = 6'd34, S_UREV = 6'd35;
  localparam logic [5:0] S_TOT = 6'd36,  S_EMIT = 6'd37;

  logic [5:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LATCH; state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat.opc == OPC_CLEAR) state_nxt = S_CLR;
        else if (stat.opc == OPC_ADD) state_nxt = S_ACHK;
        else if (stat.opc == OPC_RUN) state_nxt = S_RCHK;
        else state_nxt = S_IDLE;
      end
      S_CLR:  begin cmd.op = OP_CLR; state_nxt = S_IDLE; end
      S_ACHK: begin cmd.op = OP_ADD_CHK; state_nxt = stat.full ? S_IDLE : S_ARD; end
      S_ARD:  begin cmd.op = OP_ADD_RD; state_nxt = S_AWR; end
      S_AWR:  begin cmd.op = OP_ADD_WR; state_nxt = S_ALNK; end
      S_ALNK: begin cmd.op = OP_ADD_LINK; state_nxt = stat.side ? S_IDLE : S_ARD; end
      S_RCHK: begin cmd.op = OP_RUN_CHK; state_nxt = stat.same_st ? S_EMIT : S_LCLR; end
      S_LCLR: begin cmd.op = OP_LV_CLR; state_nxt = stat.sweep_last ? S_LSRC : S_LCLR; end
      S_LSRC: begin cmd.op = OP_LV_SRC; state_nxt = S_LPOP; end
      S_LPOP: begin cmd.op = OP_LV_POP; state_nxt = stat.qempty ? S_LEND : S_LNOD; end
      S_LNOD: begin cmd.op = OP_LV_NODE; state_nxt = S_LFST; end
      S_LFST: begin cmd.op = OP_LV_FIRST; state_nxt = S_LARC; end
      S_LARC: begin cmd.op = OP_ARC_RD; state_nxt = stat.a_none ? S_LPOP : S_LHD; end
      S_LHD:  begin cmd.op = OP_ARC_HEAD; state_nxt = S_LVIS; end
      S_LVIS: begin cmd.op = OP_LV_VISIT; state_nxt = S_LARC; end
      S_LEND: begin cmd.op = OP_LV_END; state_nxt = S_LTST; end
      S_LTST: begin state_nxt = stat.t_reached ? S_CARD : S_EMIT; end
      S_CARD: begin cmd.op = OP_CA_RD; state_nxt = S_CAWR; end
      S_CAWR: begin cmd.op = OP_CA_WR; state_nxt = stat.sweep_last ? S_GINI : S_CARD; end
      S_GINI: begin cmd.op = OP_AG_INIT; state_nxt = S_GTOP; end
      S_GTOP: begin cmd.op = OP_AG_TOP; state_nxt = stat.u_is_t ? S_BST : S_GCUR; end
      S_GCUR: begin cmd.op = OP_AG_CUR; state_nxt = S_GSCN; end
      S_GSCN: begin cmd.op = OP_ARC_RD; state_nxt = stat.a_none ? S_GDED : S_GHD; end
      S_GHD:  begin cmd.op = OP_ARC_HEAD; state_nxt = S_GTST; end
      S_GTST: begin
        cmd.op = OP_AG_TEST;
        priority if (stat.found && stat.depth_full) state_nxt = S_LCLR;
        else if (stat.found) state_nxt = S_GTOP;
        else state_nxt = S_GSCN;
      end
      S_GDED: begin cmd.op = OP_AG_DEAD; state_nxt = stat.depth_zero ? S_LCLR : S_GPOP; end
      S_GPOP: begin cmd.op = OP_AG_POP; state_nxt = S_GBCK; end
      S_GBCK: begin cmd.op = OP_AG_BACK; state_nxt = S_GTOP; end
      S_BST:  begin cmd.op = OP_BN_START; state_nxt = S_BRD; end
      S_BRD:  begin cmd.op = OP_BN_READ; state_nxt = S_BMIN; end
      S_BMIN: begin cmd.op = OP_BN_MIN; state_nxt = stat.k_more ? S_BRD : S_UARC; end
      S_UARC: begin cmd.op = OP_UP_ARC; state_nxt = S_UFWD; end
      S_UFWD: begin cmd.op = OP_UP_FWD; state_nxt = S_URRD; end
      S_URRD: begin cmd.op = OP_UP_REVRD; state_nxt = S_UREV; end
      S_UREV: begin cmd.op = OP_UP_REV; state_nxt = stat.k_more ? S_UARC : S_TOT; end
      S_TOT:  begin cmd.op = OP_TOT; state_nxt = S_GINI; end
      S_EMIT: begin cmd.op = OP_EMIT; state_nxt = stat.out_free ? S_IDLE : S_EMIT; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DISP))
    else $error("transfer not followed by dispatch");
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && stat.out_free) |=> (state_r == S_IDLE))
    else $error("result step did not return to idle");
  a_add_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALNK && !stat.side) |=> (state_r == S_ARD))
    else $error("reverse arc of edge not stored");
`endif
endmodule

[sv/max_flow_dinic_engine.sv]
// Top level of the Dinic maximum-flow engine: sequencer plus datapath.
//
// Items arrive as opcodes: clear the graph, add an edge, or run a maximum
// flow from source to sink. Each added edge writes a forward arc and a
// zero-capacity reverse arc through single-port arc memories and links each
// into its node's list. A run returns exactly one result (max_flow, status);
// clear and add return none. A run's length depends on the graph: each level
// pass clears the level memory, then takes nodes from the queue and scans
// their arcs; each phase loads the current-arc pointers; and each augmenting
// path tries arcs, enters nodes and backtracks, then finds the bottleneck and
// updates the flow of each path arc. The single read port of the arc memories
// sets the pace of these steps. Flows persist across runs, so a second run
// reports only the flow it adds. A finished result is held in an output
// register; the block takes the next item while that result waits for its
// transfer.
module max_flow_dinic_engine import mfd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [NODE_W-1:0] in_from_node,
  input  logic [NODE_W-1:0] in_to_node,
  input  logic [CAP_W-1:0]  in_capacity,
  input  logic [NODE_W-1:0] in_source_node,
  input  logic [NODE_W-1:0] in_sink_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TOT_W-1:0]  out_max_flow,
  output logic [1:0]        out_status
);
  cmd_t  cmd;
  stat_t stat;

  // sequencer: accepts items and steps the datapath
  mfd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .stat, .cmd
  );

  // datapath: graph memories, walk registers, result register
  mfd_dp u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_opcode, .in_from_node, .in_to_node, .in_capacity,
    .in_source_node, .in_sink_node,
    .out_valid, .out_ready, .out_max_flow, .out_status
  );
endmodule
